// File: hdl/toeq_pkg.sv
// Package for the time-ordered event queue.
// Holds the operation code and the beat types of the input and result channels.
// No dependencies.
`default_nettype none

package toeq_pkg;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } toeq_op_e;

  typedef struct packed {
    toeq_op_e    op;
    logic [31:0] event_time;
    logic [15:0] event_id;
    logic [31:0] event_arg;
  } toeq_in_t;

  typedef struct packed {
    logic        front_valid;
    logic [31:0] front_time;
    logic [15:0] front_id;
    logic [31:0] front_arg;
    logic [4:0]  entry_count;
    logic        push_dropped;
  } toeq_out_t;

  // Per-cycle command that every cell of the chain sees.
  typedef struct packed {
    logic push;
    logic pop;
  } toeq_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/toeq_cell.sv
// One slot of the sorted chain: holds an entry and compares it with the incoming time.
// Depends on toeq_pkg for the command struct.
`default_nettype none

module toeq_cell #(
  parameter int TIME_BITS = 32
) (
  input  wire                       clk_i,
  input  toeq_pkg::toeq_ctrl_t      ctrl_i,
  input  wire                       occupied_i,
  input  wire  [TIME_BITS-1:0]      new_time_i,
  input  wire  [15:0]               new_id_i,
  input  wire  [31:0]               new_arg_i,
  input  wire                       prev_take_i,
  input  wire  [TIME_BITS-1:0]      prev_time_i,
  input  wire  [15:0]               prev_id_i,
  input  wire  [31:0]               prev_arg_i,
  input  wire  [TIME_BITS-1:0]      next_time_i,
  input  wire  [15:0]               next_id_i,
  input  wire  [31:0]               next_arg_i,
  output logic                      take_o,
  output logic [TIME_BITS-1:0]      time_o,
  output logic [15:0]               id_o,
  output logic [31:0]               arg_o
);
  import toeq_pkg::*;

  logic [TIME_BITS-1:0] time_q, time_d;
  logic [15:0]          id_q, id_d;
  logic [31:0]          arg_q, arg_d;

  // This slot lies at or after the insert point when it is empty or holds a
  // strictly later time, so equal times keep their arrival order.
  assign take_o = !occupied_i || (time_q > new_time_i);

  always_comb begin
    time_d = time_q;
    id_d   = id_q;
    arg_d  = arg_q;
    if (ctrl_i.push && take_o) begin
      if (prev_take_i) begin
        time_d = prev_time_i;
        id_d   = prev_id_i;
        arg_d  = prev_arg_i;
      end else begin
        time_d = new_time_i;
        id_d   = new_id_i;
        arg_d  = new_arg_i;
      end
    end else if (ctrl_i.pop) begin
      time_d = next_time_i;
      id_d   = next_id_i;
      arg_d  = next_arg_i;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    id_q   <= id_d;
    arg_q  <= arg_d;
  end

  assign time_o = time_q;
  assign id_o   = id_q;
  assign arg_o  = arg_q;

endmodule

`default_nettype wire

// File: hdl/time_ordered_event_queue_unit.sv
// Top level of the time-ordered event queue: a chain of toeq_cell slots and the count.
// Depends on toeq_pkg and toeq_cell.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one beat per
//   operation: a push with time, id and argument, or a pop of the earliest
//   entry. Entries are kept sorted by time; equal times leave in arrival order.
//   Result channel (out_valid_o / out_stall_i / out_data_o) returns exactly one
//   beat per input beat: the front entry after the operation (zeros when
//   empty), the entry count and a flag for a push refused because the queue
//   was full. A pop on an empty queue changes nothing.
//   The result is registered: the result of a beat accepted at an edge is valid
//   right after it. Throughput is one beat per cycle while out_stall_i is low;
//   every slot compares its time with the pushed time in the same cycle and
//   shifts by one place, so an insert or remove moves the whole chain at once.
//   While a result waits and out_stall_i is high, in_stall_o is high and the
//   result holds steady. Reset empties the queue and drops any pending result;
//   slot contents are not cleared, only the count.
`default_nettype none

module time_ordered_event_queue_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  toeq_pkg::toeq_in_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output toeq_pkg::toeq_out_t out_data_o
);
  import toeq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic             dropped_q;

  logic             in_acc;
  logic             full;
  logic             empty;
  toeq_ctrl_t       ctrl;
  logic [TIME_BITS-1:0] new_time;

  logic                 take  [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] times [QUEUE_DEPTH];
  logic [15:0]          ids   [QUEUE_DEPTH];
  logic [31:0]          args  [QUEUE_DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty      = (count_q == '0);
  assign new_time   = TIME_BITS'(in_data_i.event_time);

  assign ctrl.push = in_acc && (in_data_i.op == OP_PUSH) && !full;
  assign ctrl.pop  = in_acc && (in_data_i.op == OP_POP) && !empty;

  always_comb begin
    count_d = count_q;
    if (ctrl.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic                 p_take;
    logic [TIME_BITS-1:0] p_time, n_time;
    logic [15:0]          p_id, n_id;
    logic [31:0]          p_arg, n_arg;

    if (k == 0) begin : g_first
      assign p_take = 1'b0;
      assign p_time = '0;
      assign p_id   = '0;
      assign p_arg  = '0;
    end else begin : g_mid
      assign p_take = take[k-1];
      assign p_time = times[k-1];
      assign p_id   = ids[k-1];
      assign p_arg  = args[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign n_time = '0;
      assign n_id   = '0;
      assign n_arg  = '0;
    end else begin : g_inner
      assign n_time = times[k+1];
      assign n_id   = ids[k+1];
      assign n_arg  = args[k+1];
    end

    toeq_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (count_q > CNT_W'(k)),
      .new_time_i  (new_time),
      .new_id_i    (in_data_i.event_id),
      .new_arg_i   (in_data_i.event_arg),
      .prev_take_i (p_take),
      .prev_time_i (p_time),
      .prev_id_i   (p_id),
      .prev_arg_i  (p_arg),
      .next_time_i (n_time),
      .next_id_i   (n_id),
      .next_arg_i  (n_arg),
      .take_o      (take[k]),
      .time_o      (times[k]),
      .id_o        (ids[k]),
      .arg_o       (args[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      dropped_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
        dropped_q   <= (in_data_i.op == OP_PUSH) && full;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The result is formed from the slot registers, which only move when a
  // beat is accepted, so it holds steady while the receiver stalls.
  always_comb begin
    out_data_o              = '0;
    out_data_o.front_valid  = !empty;
    out_data_o.entry_count  = 5'(count_q);
    out_data_o.push_dropped = dropped_q;
    if (!empty) begin
      out_data_o.front_time = 32'(times[0]);
      out_data_o.front_id   = ids[0];
      out_data_o.front_arg  = args[0];
    end
  end

  assign out_valid_o = out_valid_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_drop_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && dropped_q) |-> full)
    else $error("push dropped while queue not full");

  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("pop did not decrement the count");

  a_front_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (times[0] <= times[1]))
    else $error("front entries out of time order");

endmodule

`default_nettype wire
